### rtl/grrd_pkg.sv
// ----------------------------------------------------------------------------
// grrd_pkg
// shared types, command codes and register addresses of the rate device
// ----------------------------------------------------------------------------
package grrd_pkg;

  localparam logic [1:0] CMD_PULSE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  localparam logic [7:0] ADDR_ID      = 8'h00;
  localparam logic [7:0] ADDR_VERSION = 8'h01;
  localparam logic [7:0] ADDR_DYNAMIC = 8'h03;
  localparam logic [7:0] ADDR_STATIC  = 8'h06;
  localparam logic [7:0] ADDR_UNREAD  = 8'h09;
  localparam logic [7:0] ADDR_DEVADDR = 8'h10;
  localparam logic [7:0] ADDR_HV      = 8'h11;
  localparam logic [7:0] ADDR_SENS    = 8'h12;
  localparam logic [7:0] ADDR_LED     = 8'h14;
  localparam logic [7:0] ADDR_LOWPWR  = 8'h0C;

  localparam logic [7:0]  DEVICE_ID    = 8'h7D;
  localparam logic [7:0]  FW_VERSION   = 8'h01;
  localparam logic [15:0] SENS_RESET   = 16'd18;
  localparam logic [7:0]  DEVADDR_RESET = 8'h66;
  localparam logic [15:0] RATE_SCALE   = 16'd36000;
  localparam logic [23:0] RATE_MAX     = 24'hFFFFFF;

  // controller to datapath
  typedef struct packed {
    logic pulse;        // count one pulse
    logic write_reg;    // apply register write
    logic clear_unread; // clear-on-read of pulse counter
    logic load_out;     // latch read word into shifter
    logic shift_out;    // next output byte
    logic push;         // store second count into window
    logic sum_start;    // clear sums, start scan
    logic sum_step;     // read next window entry
    logic div_start;    // start a division
    logic div_step;     // one quotient bit
    logic div_sel;      // 0 static, 1 dynamic
    logic div_store;    // write quotient into rate
  } grrd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       sum_done;
    logic       div_done;
    logic       unread_sel; // address selects the clear-on-read counter
    logic [1:0] read_len;   // 0 means unknown address
  } grrd_status_t;

endpackage

### rtl/grrd_if.sv
// ----------------------------------------------------------------------------
// grrd_in_if / grrd_out_if
// valid/ready channels of the rate device
// ----------------------------------------------------------------------------
interface grrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  reg_addr;
  logic [15:0] write_data;
  modport source (output valid, command, reg_addr, write_data, input ready);
  modport sink   (input valid, command, reg_addr, write_data, output ready);
endinterface

interface grrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       last_byte;
  modport source (output valid, read_byte, last_byte, input ready);
  modport sink   (input valid, read_byte, last_byte, output ready);
endinterface

### rtl/geiger_rate_register_device_top.sv
// ----------------------------------------------------------------------------
// geiger_rate_register_device_top
// radiation counter register device with sliding-window dose rate
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | handshake
//  in_ch   | in  | command, reg_addr, write_data   | valid/ready
//  out_ch  | out | read_byte, last_byte            | valid/ready
//
// pulses and writes leave the block idle; a read sends its bytes, one per
// out_ch handshake, and a tick runs the one-entry-per-cycle window scan
// and then the bit-serial divider, for the static and then the dynamic rate
// input is held off while a tick computes or read bytes are pending
// synchronous active-high reset; window memory is not cleared, only
// filled entries are ever summed
// ----------------------------------------------------------------------------
module geiger_rate_register_device_top #(
  parameter int WINDOW_DEPTH   = 500,
  parameter int RECENT_SECONDS = 60
) (
  input logic      clk,
  input logic      rst,
  grrd_in_if.sink  in_ch,
  grrd_out_if.source out_ch
);
  import grrd_pkg::*;

  grrd_cmd_t    cmd;
  grrd_status_t status;

  // controller: handshakes, tick sequencing, byte pacing
  grrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_command(in_ch.command),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last_byte),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: registers, window, scan, divider and read shifter
  grrd_datapath #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .RECENT_SECONDS(RECENT_SECONDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .reg_addr  (in_ch.reg_addr),
    .write_data(in_ch.write_data),
    .read_byte (out_ch.read_byte),
    .last_byte (out_ch.last_byte)
  );

endmodule

### rtl/grrd_datapath.sv
// ----------------------------------------------------------------------------
// grrd_datapath
// counters, window memory, summing scan, serial divider, read shifter
// ----------------------------------------------------------------------------
module grrd_datapath #(
  parameter int WINDOW_DEPTH   = 500,
  parameter int RECENT_SECONDS = 60
) (
  input  logic                   clk,
  input  logic                   rst,
  input  grrd_pkg::grrd_cmd_t    cmd,
  output grrd_pkg::grrd_status_t status,
  input  logic [7:0]             reg_addr,
  input  logic [15:0]            write_data,
  output logic [7:0]             read_byte,
  output logic                   last_byte
);
  import grrd_pkg::*;

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 16 + FW;        // sum width
  localparam int NW = SW + 16;        // numerator width
  localparam int DW = FW + 16;        // denominator width
  localparam int CW = $clog2(NW + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F   = FW'(WINDOW_DEPTH);
  localparam logic [FW-1:0] RECENT_F  = FW'(RECENT_SECONDS);

  logic [15:0] window_store [WINDOW_DEPTH];
  logic [PW-1:0] window_pointer, scan_ptr;
  logic [FW-1:0] window_fill, scan_cnt;
  logic [15:0] second_pulses, unread_pulses, sensitivity_value;
  logic [7:0]  device_address;
  logic        hv_enable, led_enable, low_power;
  logic [SW-1:0] total_sum, recent_sum;
  logic [23:0] static_rate, dynamic_rate;
  logic [15:0] rd_data;
  logic        rd_valid, scan_busy;
  logic [FW-1:0] rd_idx;

  // window write and registered read
  always_ff @(posedge clk) begin
    if (cmd.push) window_store[window_pointer] <= second_pulses;
    rd_data <= window_store[scan_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_pointer <= '0;
      window_fill <= '0;
      second_pulses <= '0;
      unread_pulses <= '0;
      sensitivity_value <= SENS_RESET;
      device_address <= DEVADDR_RESET;
      hv_enable <= 1'b1;
      led_enable <= 1'b1;
      low_power <= 1'b0;
    end else begin
      if (cmd.pulse) begin
        second_pulses <= second_pulses + 16'd1;
        unread_pulses <= unread_pulses + 16'd1;
      end
      if (cmd.clear_unread) unread_pulses <= '0;
      if (cmd.push) begin
        second_pulses <= '0;
        window_pointer <= (window_pointer == LAST_SLOT) ? '0 : window_pointer + 1'b1;
        if (window_fill != DEPTH_F) window_fill <= window_fill + 1'b1;
      end
      if (cmd.write_reg) begin
        unique case (reg_addr)
          ADDR_DEVADDR: device_address <= write_data[7:0];
          ADDR_HV:      if (write_data[7:1] == '0) hv_enable <= write_data[0];
          ADDR_SENS:    sensitivity_value <= write_data;
          ADDR_LED:     if (write_data[7:1] == '0) led_enable <= write_data[0];
          ADDR_LOWPWR:  if (write_data[7:1] == '0) low_power <= write_data[0];
          default: ;
        endcase
      end
    end
  end

  // scan newest to oldest, one entry per cycle, read data registered
  logic [FW-1:0] recent_n;
  assign recent_n = (window_fill < RECENT_F) ? window_fill : RECENT_F;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      rd_valid <= 1'b0;
      total_sum <= '0;
      recent_sum <= '0;
      scan_ptr <= '0;
      scan_cnt <= '0;
      rd_idx <= '0;
    end else begin
      rd_valid <= 1'b0;
      if (cmd.sum_start) begin
        total_sum <= '0;
        recent_sum <= '0;
        scan_busy <= 1'b1;
        scan_cnt <= '0;
        scan_ptr <= (window_pointer == '0) ? LAST_SLOT : window_pointer - 1'b1;
      end else if (cmd.sum_step && scan_busy) begin
        if (scan_cnt == window_fill) begin
          scan_busy <= 1'b0;
        end else begin
          rd_valid <= 1'b1;
          rd_idx <= scan_cnt;
          scan_cnt <= scan_cnt + 1'b1;
          scan_ptr <= (scan_ptr == '0) ? LAST_SLOT : scan_ptr - 1'b1;
        end
      end
      if (rd_valid) begin
        total_sum <= total_sum + SW'(rd_data);
        if (rd_idx < recent_n) recent_sum <= recent_sum + SW'(rd_data);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NW-1:0] num_sh, quo;
  logic [DW:0]   rem;
  logic [DW-1:0] den;
  logic [CW-1:0] div_cnt;
  logic          den_zero;
  logic [DW:0]   rem_sh;
  logic [SW-1:0] sum_sel;
  logic [FW-1:0] n_sel;
  logic [23:0]   rate_q;

  assign sum_sel = cmd.div_sel ? recent_sum : total_sum;
  assign n_sel   = cmd.div_sel ? recent_n : window_fill;
  assign rem_sh  = {rem[DW-1:0], num_sh[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      num_sh <= NW'(sum_sel) * NW'(RATE_SCALE);
      den <= DW'(n_sel) * DW'(sensitivity_value);
      den_zero <= (n_sel == '0) || (sensitivity_value == '0);
      rem <= '0;
      quo <= '0;
      div_cnt <= CW'(NW);
    end else if (cmd.div_step && div_cnt != '0) begin
      num_sh <= num_sh << 1;
      div_cnt <= div_cnt - 1'b1;
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign rate_q = (den_zero || quo[NW-1:24] != '0) ? RATE_MAX : quo[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      static_rate <= '0;
      dynamic_rate <= '0;
    end else if (cmd.div_store) begin
      if (cmd.div_sel) dynamic_rate <= rate_q;
      else static_rate <= rate_q;
    end
  end

  // read decode and output shifter
  logic [23:0] rd_word;
  logic [1:0]  rd_len;
  always_comb begin
    rd_word = '0;
    rd_len = 2'd0;
    unique case (reg_addr)
      ADDR_ID:      begin rd_word = {16'd0, DEVICE_ID}; rd_len = 2'd1; end
      ADDR_VERSION: begin rd_word = {16'd0, FW_VERSION}; rd_len = 2'd1; end
      ADDR_DYNAMIC: begin rd_word = dynamic_rate; rd_len = 2'd3; end
      ADDR_STATIC:  begin rd_word = static_rate; rd_len = 2'd3; end
      ADDR_UNREAD:  begin rd_word = {8'd0, unread_pulses}; rd_len = 2'd2; end
      ADDR_DEVADDR: begin rd_word = {16'd0, device_address}; rd_len = 2'd1; end
      ADDR_HV:      begin rd_word = {23'd0, hv_enable}; rd_len = 2'd1; end
      ADDR_SENS:    begin rd_word = {8'd0, sensitivity_value}; rd_len = 2'd2; end
      ADDR_LED:     begin rd_word = {23'd0, led_enable}; rd_len = 2'd1; end
      ADDR_LOWPWR:  begin rd_word = {23'd0, low_power}; rd_len = 2'd1; end
      default: ;
    endcase
  end

  logic [23:0] out_sh;
  logic [1:0]  out_left;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      // left-align so the top byte goes first
      unique case (rd_len)
        2'd3:    out_sh <= rd_word;
        2'd2:    out_sh <= {rd_word[15:0], 8'd0};
        default: out_sh <= {rd_word[7:0], 16'd0};
      endcase
      out_left <= rd_len;
    end else if (cmd.shift_out) begin
      out_sh <= {out_sh[15:0], 8'd0};
      out_left <= out_left - 2'd1;
    end
  end

  assign read_byte = out_sh[23:16];
  assign last_byte = (out_left == 2'd1);

  assign status.sum_done   = !scan_busy && !rd_valid;
  assign status.div_done   = (div_cnt == '0);
  assign status.unread_sel = (reg_addr == ADDR_UNREAD);
  assign status.read_len   = rd_len;

endmodule

### rtl/grrd_ctrl.sv
// ----------------------------------------------------------------------------
// grrd_ctrl
// sequencer for transactions, tick processing and byte output
// ----------------------------------------------------------------------------
module grrd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_command,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_last,
  input  grrd_pkg::grrd_status_t status,
  output grrd_pkg::grrd_cmd_t    cmd
);
  import grrd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SUM    = 7'b0000010,
    S_DIV_S  = 7'b0000100,
    S_WAIT_S = 7'b0001000,
    S_DIV_D  = 7'b0010000,
    S_WAIT_D = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   take;
  logic   in_sum_d;
  logic   sum_first;

  assign in_ready  = (state == S_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  // scan starts the cycle after push so the new entry is in memory
  assign sum_first = (state == S_SUM) && !in_sum_d;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (take) begin
        unique case (in_command)
          CMD_PULSE: cmd.pulse = 1'b1;
          CMD_WRITE: cmd.write_reg = 1'b1;
          CMD_TICK: begin
            cmd.push = 1'b1;
            state_next = S_SUM;
          end
          default: if (status.read_len != 2'd0) begin
            cmd.load_out = 1'b1;
            cmd.clear_unread = status.unread_sel;
            state_next = S_OUT;
          end
        endcase
      end
      S_SUM: if (sum_first) begin
        cmd.sum_start = 1'b1;
      end else begin
        cmd.sum_step = 1'b1;
        if (status.sum_done) state_next = S_DIV_S;
      end
      S_DIV_S: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT_S;
      end
      S_WAIT_S: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next = S_DIV_D;
        end
      end
      S_DIV_D: begin
        cmd.div_sel = 1'b1;
        cmd.div_start = 1'b1;
        state_next = S_WAIT_D;
      end
      S_WAIT_D: begin
        cmd.div_sel = 1'b1;
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OUT: if (out_ready) begin
        cmd.shift_out = 1'b1;
        if (out_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // marks cycles after the first one in the summing state
  always_ff @(posedge clk) begin
    if (rst) in_sum_d <= 1'b0;
    else     in_sum_d <= (state == S_SUM);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

### rtl/grrd_checker.sv
// ----------------------------------------------------------------------------
// grrd_checker
// port-level checks on the rate device
// ----------------------------------------------------------------------------
module grrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_byte,
  input logic       last_byte
);
  // no input taken while bytes are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during read output");

  // stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(last_byte))
    else $error("output changed while stalled");

  // after the last byte the block is ready again
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte |=> in_ready && !out_valid)
    else $error("not ready after final byte");
endmodule

bind geiger_rate_register_device_top grrd_checker u_grrd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .read_byte(out_ch.read_byte),
  .last_byte(out_ch.last_byte)
);
